// ===== hw/rtl/atpts_pkg.sv =====
`default_nettype none

package atpts_pkg;

    // Field widths.
    localparam int AMOUNT_BITS = 24;
    localparam int UNIT_BITS   = 16;
    localparam int TRANS_BITS  = AMOUNT_BITS + 1;
    localparam int TRIES_BITS  = UNIT_BITS + 1;
    localparam int STATUS_BITS = 3;
    localparam int CFG_IDX_BITS = 3;
    localparam int MODE_BITS   = 2;

    // Output tdata layout, lowest bit first.
    localparam int OUT_USED_BITS = 3 + 2 * AMOUNT_BITS;
    localparam int OUT_BITS      = ((OUT_USED_BITS + 7) / 8) * 8;
    localparam int IN_BITS       = ((AMOUNT_BITS + 7) / 8) * 8;

    typedef logic [STATUS_BITS-1:0] status_t;

    // Result status codes.
    localparam status_t ST_TICK    = 3'd0;
    localparam status_t ST_STARTED = 3'd1;
    localparam status_t ST_BUSY    = 3'd2;
    localparam status_t ST_ZERO    = 3'd3;
    localparam status_t ST_FAILED  = 3'd4;

    // Request kinds.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_PAY  = 1'b1;

    // Payment modes.
    localparam logic [MODE_BITS-1:0] MODE_BILLS_ONLY = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_COINS_ONLY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAY_MODE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BILL_UNIT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COIN_UNIT    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BILL_HIGH_MS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BILL_LOW_MS  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COIN_HIGH_MS = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COIN_LOW_MS  = 3'd6;

endpackage

`default_nettype wire

// ===== hw/rtl/amount_to_pulse_train_splitter.sv =====
`default_nettype none
// Channel   | Signals                        | Carries
// s (in)    | s_tvalid s_tready s_tdata/user | tick or payment request
// m (out)   | m_tvalid m_tready m_tdata/user | line levels, busy, status, counts
// cfg       | cfg_we cfg_index cfg_data      | register writes, no read-back
//
// A split runs through one shared restoring divider, one to four divisions, plus a
// search that tries one bill count at a time in the all mode (up to coin_unit tries).
// Reset clears all control and phase state and loads the register defaults.
// The input is not ready while a split runs or a result waits unaccepted.

module amount_to_pulse_train_splitter
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // [23:0] amount
    input  wire logic [atpts_pkg::IN_BITS-1:0] s_tdata,
    // [0] req_type
    input  wire logic s_tuser,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // [0] bill_line, [1] coin_line, [2] busy_res, [26:3] bill_pulses,
    // [50:27] coin_pulses, rest zero
    output logic [atpts_pkg::OUT_BITS-1:0] m_tdata,
    // [2:0] status
    output logic [atpts_pkg::STATUS_BITS-1:0] m_tuser,
    input  wire logic cfg_we,
    input  wire logic [atpts_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [atpts_pkg::UNIT_BITS-1:0] cfg_data
);

    localparam int AB = atpts_pkg::AMOUNT_BITS;
    localparam int UB = atpts_pkg::UNIT_BITS;
    localparam int CB = $clog2(AB);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_LOOP = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Division purposes.
    localparam logic [2:0] OP_BILL = 3'd0;  // amount / bill_unit
    localparam logic [2:0] OP_COIN = 3'd1;  // amount / coin_unit
    localparam logic [2:0] OP_KB   = 3'd2;  // amount / bill_unit, start search
    localparam logic [2:0] OP_BC   = 3'd3;  // bill_unit mod coin_unit
    localparam logic [2:0] OP_RC   = 3'd4;  // remainder mod coin_unit
    localparam logic [2:0] OP_CP   = 3'd5;  // final coin count

    // Configuration registers.
    logic [atpts_pkg::MODE_BITS-1:0] pay_mode_reg;
    logic [UB-1:0] bill_unit_reg, coin_unit_reg;
    logic [UB-1:0] bill_high_reg, bill_low_reg, coin_high_reg, coin_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pay_mode_reg  <= '0;
            bill_unit_reg <= UB'(100);
            coin_unit_reg <= UB'(10);
            bill_high_reg <= UB'(50);
            bill_low_reg  <= UB'(50);
            coin_high_reg <= UB'(50);
            coin_low_reg  <= UB'(50);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                atpts_pkg::CFG_PAY_MODE:     pay_mode_reg  <= cfg_data[1:0];
                atpts_pkg::CFG_BILL_UNIT:    bill_unit_reg <= cfg_data;
                atpts_pkg::CFG_COIN_UNIT:    coin_unit_reg <= cfg_data;
                atpts_pkg::CFG_BILL_HIGH_MS: bill_high_reg <= cfg_data;
                atpts_pkg::CFG_BILL_LOW_MS:  bill_low_reg  <= cfg_data;
                atpts_pkg::CFG_COIN_HIGH_MS: coin_high_reg <= cfg_data;
                atpts_pkg::CFG_COIN_LOW_MS:  coin_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Ticks for one level, a zero setting counting as one tick.
    function automatic logic [UB-1:0] level_time(input logic coin, input logic high,
                                                 input logic [UB-1:0] bh,
                                                 input logic [UB-1:0] bl,
                                                 input logic [UB-1:0] ch,
                                                 input logic [UB-1:0] cl);
        logic [UB-1:0] t;
        begin
            t = coin ? (high ? ch : cl) : (high ? bh : bl);
            level_time = (t == '0) ? UB'(1) : t;
        end
    endfunction

    // Control and phase state.
    logic [1:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic exact_reg, exact_next;
    logic phase_active_reg, phase_active_next;
    logic line_level_reg, line_level_next;
    logic phase_coin_reg, phase_coin_next;
    logic [atpts_pkg::TRANS_BITS-1:0] trans_reg, trans_next;
    logic [UB-1:0] timer_reg, timer_next;
    logic coin_queued_reg, coin_queued_next;
    logic [AB-1:0] queued_cnt_reg, queued_cnt_next;
    logic out_valid_reg, out_valid_next;
    logic [atpts_pkg::OUT_BITS-1:0] out_data_reg, out_data_next;
    atpts_pkg::status_t out_status_reg, out_status_next;

    // Datapath registers.
    logic [AB-1:0] k_reg, k_next;
    logic [AB-1:0] rem_reg, rem_next;
    logic [UB-1:0] bmc_reg, bmc_next;
    logic [UB-1:0] rmod_reg, rmod_next;
    logic [atpts_pkg::TRIES_BITS-1:0] tries_reg, tries_next;
    atpts_pkg::status_t res_status_reg, res_status_next;
    logic [AB-1:0] res_bp_reg, res_bp_next;
    logic [AB-1:0] res_cp_reg, res_cp_next;

    // Shared divider registers.
    logic [AB-1:0] div_q_reg, div_q_next;
    logic [UB-1:0] div_r_reg, div_r_next;
    logic [UB-1:0] div_d_reg, div_d_next;
    logic [CB-1:0] div_cnt_reg, div_cnt_next;

    // One restoring division step.
    logic [UB:0] div_trial;
    logic div_fits;
    logic [UB-1:0] div_r_step;
    logic [AB-1:0] div_q_step;

    always_comb
    begin
        div_trial  = {div_r_reg, div_q_reg[AB-1]};
        div_fits   = div_trial >= {1'b0, div_d_reg};
        div_r_step = div_fits ? UB'(div_trial - {1'b0, div_d_reg}) : div_trial[UB-1:0];
        div_q_step = {div_q_reg[AB-2:0], div_fits};
    end

    // Residue step of the split search.
    logic [UB:0] rmod_sum;
    logic [UB-1:0] rmod_step;

    always_comb
    begin
        rmod_sum  = {1'b0, rmod_reg} + {1'b0, bmc_reg};
        rmod_step = (rmod_sum >= {1'b0, coin_unit_reg})
                    ? UB'(rmod_sum - {1'b0, coin_unit_reg}) : rmod_sum[UB-1:0];
    end

    logic out_free;
    logic accept;
    logic [AB-1:0] in_amt;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign in_amt   = s_tdata[AB-1:0];

    // Sequencer, phase update and result formation.
    always_comb
    begin
        logic do_tick, do_commit;
        logic start_coin;
        logic [AB-1:0] start_cnt;
        atpts_pkg::status_t st;
        logic [AB-1:0] bp, cp;

        state_next        = state_reg;
        op_next           = op_reg;
        exact_next        = exact_reg;
        phase_active_next = phase_active_reg;
        line_level_next   = line_level_reg;
        phase_coin_next   = phase_coin_reg;
        trans_next        = trans_reg;
        timer_next        = timer_reg;
        coin_queued_next  = coin_queued_reg;
        queued_cnt_next   = queued_cnt_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_data_next     = out_data_reg;
        out_status_next   = out_status_reg;
        k_next            = k_reg;
        rem_next          = rem_reg;
        bmc_next          = bmc_reg;
        rmod_next         = rmod_reg;
        tries_next        = tries_reg;
        res_status_next   = res_status_reg;
        res_bp_next       = res_bp_reg;
        res_cp_next       = res_cp_reg;
        div_q_next        = div_q_reg;
        div_r_next        = div_r_reg;
        div_d_next        = div_d_reg;
        div_cnt_next      = div_cnt_reg;

        do_tick    = 1'b0;
        do_commit  = 1'b0;
        start_coin = 1'b0;
        start_cnt  = '0;
        st         = atpts_pkg::ST_TICK;
        bp         = '0;
        cp         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    div_q_next = in_amt;
                    div_r_next = '0;
                    div_cnt_next = CB'(AB - 1);
                    if (s_tuser == atpts_pkg::REQ_TICK)
                    begin
                        do_tick   = 1'b1;
                        do_commit = 1'b1;
                    end
                    else if (phase_active_reg || coin_queued_reg)
                    begin
                        do_commit = 1'b1;
                        st        = atpts_pkg::ST_BUSY;
                    end
                    else if (in_amt == '0)
                    begin
                        do_commit = 1'b1;
                        st        = atpts_pkg::ST_ZERO;
                    end
                    else if (pay_mode_reg == atpts_pkg::MODE_BILLS_ONLY)
                    begin
                        if (bill_unit_reg == '0)
                        begin
                            do_commit = 1'b1;
                            st        = atpts_pkg::ST_FAILED;
                        end
                        else
                        begin
                            div_d_next = bill_unit_reg;
                            op_next    = OP_BILL;
                            exact_next = 1'b0;
                            state_next = S_DIV;
                        end
                    end
                    else if (pay_mode_reg == atpts_pkg::MODE_COINS_ONLY)
                    begin
                        if (coin_unit_reg == '0)
                        begin
                            do_commit = 1'b1;
                            st        = atpts_pkg::ST_FAILED;
                        end
                        else
                        begin
                            div_d_next = coin_unit_reg;
                            op_next    = OP_COIN;
                            exact_next = 1'b0;
                            state_next = S_DIV;
                        end
                    end
                    else if (bill_unit_reg == '0 && coin_unit_reg == '0)
                    begin
                        do_commit = 1'b1;
                        st        = atpts_pkg::ST_FAILED;
                    end
                    else if (bill_unit_reg == '0)
                    begin
                        div_d_next = coin_unit_reg;
                        op_next    = OP_COIN;
                        exact_next = 1'b1;
                        state_next = S_DIV;
                    end
                    else if (coin_unit_reg == '0)
                    begin
                        div_d_next = bill_unit_reg;
                        op_next    = OP_BILL;
                        exact_next = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        div_d_next = bill_unit_reg;
                        op_next    = OP_KB;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                div_q_next   = div_q_step;
                div_r_next   = div_r_step;
                div_cnt_next = div_cnt_reg - CB'(1);
                if (div_cnt_reg == '0)
                begin
                    // Division finished: quotient div_q_step, remainder div_r_step.
                    div_cnt_next = CB'(AB - 1);
                    div_r_next   = '0;
                    res_bp_next  = '0;
                    res_cp_next  = '0;
                    unique case (op_reg)
                        OP_BILL, OP_COIN:
                        begin
                            state_next = S_DONE;
                            if ((exact_reg && div_r_step != '0) ||
                                (!exact_reg && div_q_step == '0))
                            begin
                                res_status_next = atpts_pkg::ST_FAILED;
                            end
                            else
                            begin
                                res_status_next = atpts_pkg::ST_STARTED;
                                if (op_reg == OP_BILL)
                                    res_bp_next = div_q_step;
                                else
                                    res_cp_next = div_q_step;
                            end
                        end
                        OP_KB:
                        begin
                            k_next     = div_q_step;
                            rem_next   = AB'(div_r_step);
                            div_q_next = AB'(bill_unit_reg);
                            div_d_next = coin_unit_reg;
                            op_next    = OP_BC;
                        end
                        OP_BC:
                        begin
                            bmc_next   = div_r_step;
                            div_q_next = rem_reg;
                            op_next    = OP_RC;
                        end
                        OP_RC:
                        begin
                            rmod_next  = div_r_step;
                            tries_next = '0;
                            state_next = S_LOOP;
                        end
                        OP_CP:
                        begin
                            res_status_next = atpts_pkg::ST_STARTED;
                            res_bp_next     = k_reg;
                            res_cp_next     = div_q_step;
                            state_next      = S_DONE;
                        end
                        default:
                        begin
                            res_status_next = atpts_pkg::ST_FAILED;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_LOOP:
            begin
                // One bill count per cycle, largest first.
                if (rmod_reg == '0)
                begin
                    div_q_next   = rem_reg;
                    div_r_next   = '0;
                    div_cnt_next = CB'(AB - 1);
                    op_next      = OP_CP;
                    state_next   = S_DIV;
                end
                else if (k_reg == '0 ||
                         (tries_reg + 1'b1) >= {1'b0, coin_unit_reg})
                begin
                    res_status_next = atpts_pkg::ST_FAILED;
                    res_bp_next     = '0;
                    res_cp_next     = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    tries_next = tries_reg + 1'b1;
                    k_next     = k_reg - AB'(1);
                    rem_next   = rem_reg + AB'(bill_unit_reg);
                    rmod_next  = rmod_step;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    do_commit = 1'b1;
                    st        = res_status_reg;
                    bp        = res_bp_reg;
                    cp        = res_cp_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Time step of the pulse train.
        if (do_tick && phase_active_reg)
        begin
            if (timer_reg > UB'(1))
            begin
                timer_next = timer_reg - UB'(1);
            end
            else if (trans_reg == '0)
            begin
                timer_next        = '0;
                phase_active_next = 1'b0;
                line_level_next   = 1'b0;
                phase_coin_next   = 1'b0;
                if (coin_queued_reg)
                begin
                    coin_queued_next = 1'b0;
                    queued_cnt_next  = '0;
                    start_coin       = 1'b1;
                    start_cnt        = queued_cnt_reg;
                end
            end
            else
            begin
                line_level_next = !line_level_reg;
                trans_next      = trans_reg - 1'b1;
                timer_next      = level_time(phase_coin_reg, !line_level_reg,
                                             bill_high_reg, bill_low_reg,
                                             coin_high_reg, coin_low_reg);
            end
        end

        // Start of a train after a successful split.
        if (do_commit && st == atpts_pkg::ST_STARTED)
        begin
            if (bp != '0)
            begin
                coin_queued_next = (cp != '0);
                queued_cnt_next  = cp;
                start_cnt        = bp;
            end
            else
            begin
                coin_queued_next = 1'b0;
                queued_cnt_next  = '0;
                start_coin       = 1'b1;
                start_cnt        = cp;
            end
            phase_active_next = 1'b1;
            phase_coin_next   = start_coin;
            line_level_next   = 1'b1;
            trans_next        = {start_cnt, 1'b0} - 1'b1;
            timer_next        = level_time(start_coin, 1'b1, bill_high_reg, bill_low_reg,
                                           coin_high_reg, coin_low_reg);
        end
        else if (start_coin)
        begin
            phase_active_next = 1'b1;
            phase_coin_next   = 1'b1;
            line_level_next   = 1'b1;
            trans_next        = {start_cnt, 1'b0} - 1'b1;
            timer_next        = level_time(1'b1, 1'b1, bill_high_reg, bill_low_reg,
                                           coin_high_reg, coin_low_reg);
        end

        // Result register load.
        if (do_commit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = st;
            out_data_next   = '0;
            out_data_next[0] = phase_active_next && line_level_next && !phase_coin_next;
            out_data_next[1] = phase_active_next && line_level_next && phase_coin_next;
            out_data_next[2] = phase_active_next || coin_queued_next;
            out_data_next[3 +: AB]      = bp;
            out_data_next[3 + AB +: AB] = cp;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_BILL;
            exact_reg        <= 1'b0;
            phase_active_reg <= 1'b0;
            line_level_reg   <= 1'b0;
            phase_coin_reg   <= 1'b0;
            trans_reg        <= '0;
            timer_reg        <= '0;
            coin_queued_reg  <= 1'b0;
            queued_cnt_reg   <= '0;
            out_valid_reg    <= 1'b0;
            div_cnt_reg      <= '0;
            tries_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            exact_reg        <= exact_next;
            phase_active_reg <= phase_active_next;
            line_level_reg   <= line_level_next;
            phase_coin_reg   <= phase_coin_next;
            trans_reg        <= trans_next;
            timer_reg        <= timer_next;
            coin_queued_reg  <= coin_queued_next;
            queued_cnt_reg   <= queued_cnt_next;
            out_valid_reg    <= out_valid_next;
            div_cnt_reg      <= div_cnt_next;
            tries_reg        <= tries_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        k_reg          <= k_next;
        rem_reg        <= rem_next;
        bmc_reg        <= bmc_next;
        rmod_reg       <= rmod_next;
        res_status_reg <= res_status_next;
        res_bp_reg     <= res_bp_next;
        res_cp_reg     <= res_cp_next;
        div_q_reg      <= div_q_next;
        div_r_reg      <= div_r_next;
        div_d_reg      <= div_d_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/atpts_checker.sv =====
`default_nettype none

module atpts_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [atpts_pkg::OUT_BITS-1:0] m_tdata,
    input wire logic [atpts_pkg::STATUS_BITS-1:0] m_tuser
);

    localparam int AB = atpts_pkg::AMOUNT_BITS;

    // Counts appear only on a started request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != atpts_pkg::ST_STARTED |->
            m_tdata[3 +: AB] == '0 && m_tdata[3 + AB +: AB] == '0)
        else $error("pulse counts without a started request");

    // A started request always leaves the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == atpts_pkg::ST_STARTED |-> m_tdata[2])
        else $error("started request not busy");

    // Only one line can be high, and only while busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (!(m_tdata[0] || m_tdata[1]) || m_tdata[2]))
        else $error("line levels inconsistent with busy");

    // A busy request result leaves the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == atpts_pkg::ST_BUSY |-> m_tdata[2])
        else $error("busy rejection while idle");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind amount_to_pulse_train_splitter atpts_checker u_atpts_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import atpts_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  CYCLE_LIMIT = 20000000;
    localparam int  HOLD_CYCLES = 300;

    // One expected result, split into its fields.
    typedef struct packed {
        logic              bill_line;
        logic              coin_line;
        logic              busy;
        status_t           status;
        logic [23:0]       bill_pulses;
        logic [23:0]       coin_pulses;
    } pulse_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_BITS-1:0]   s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_BITS-1:0]  m_tdata;
    logic [STATUS_BITS-1:0] m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [UNIT_BITS-1:0] cfg_data;

    // Shadow registers of the block.
    logic [1:0]  mode_r;
    logic [15:0] bill_unit_r, coin_unit_r;
    logic [15:0] bill_high_r, bill_low_r, coin_high_r, coin_low_r;

    // Shadow pulse train state.
    logic        train_on, line_hi, train_is_coin;
    logic [24:0] edges_left;
    logic [15:0] level_left;
    logic        coin_waiting;
    logic [23:0] coin_waiting_count;

    pulse_result_t pending_results[$];
    int          errors;
    int          cycles;
    bit          tx_calm;
    bit          rx_calm;
    bit          hold_start;
    int          hold_left;
    int          stall_left;

    amount_to_pulse_train_splitter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Duration of one line level; a zero register counts as one tick.
    function automatic logic [15:0] level_ticks(logic coin, logic high);
        logic [15:0] t;
        if (coin)
            t = high ? coin_high_r : coin_low_r;
        else
            t = high ? bill_high_r : bill_low_r;
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    function automatic void start_train(logic coin, logic [23:0] count);
        train_on      = 1'b1;
        train_is_coin = coin;
        line_hi       = 1'b1;
        edges_left    = (25'(count) << 1) - 25'd1;
        level_left    = level_ticks(coin, 1'b1);
    endfunction

    // One millisecond of the pulse generator.
    function automatic void advance_ms();
        logic [23:0] n;
        if (!train_on)
            return;
        if (level_left > 16'd1)
        begin
            level_left = level_left - 16'd1;
            return;
        end
        level_left = 16'd0;
        if (edges_left == 25'd0)
        begin
            train_on      = 1'b0;
            line_hi       = 1'b0;
            train_is_coin = 1'b0;
            if (coin_waiting)
            begin
                n = coin_waiting_count;
                coin_waiting       = 1'b0;
                coin_waiting_count = 24'd0;
                start_train(1'b1, n);
            end
            return;
        end
        line_hi    = ~line_hi;
        edges_left = edges_left - 25'd1;
        level_left = level_ticks(train_is_coin, line_hi);
    endfunction

    // Splits an amount into bill and coin counts; returns 0 when no split exists.
    function automatic bit plan_split(longint unsigned amt,
                                      output longint unsigned bills,
                                      output longint unsigned coins);
        longint unsigned b, c, k, rem, tries;
        b = bill_unit_r;
        c = coin_unit_r;
        bills = 0;
        coins = 0;
        if (amt == 0 || (b == 0 && c == 0))
            return 0;
        if (mode_r == MODE_BILLS_ONLY)
        begin
            if (b == 0 || amt / b == 0)
                return 0;
            bills = amt / b;
            return 1;
        end
        if (mode_r == MODE_COINS_ONLY)
        begin
            if (c == 0 || amt / c == 0)
                return 0;
            coins = amt / c;
            return 1;
        end
        if (b == 0)
        begin
            if (amt % c != 0)
                return 0;
            coins = amt / c;
            return 1;
        end
        if (c == 0)
        begin
            if (amt % b != 0)
                return 0;
            bills = amt / b;
            return 1;
        end
        // Walk down from the largest bill count until the rest is whole coins.
        k = amt / b;
        tries = 0;
        forever
        begin
            rem = amt - k * b;
            if (rem % c == 0 && !(k == 0 && rem == 0))
            begin
                bills = k;
                coins = rem / c;
                return 1;
            end
            tries++;
            if (k == 0 || tries >= c)
                return 0;
            k--;
        end
    endfunction

    // Result that the block must give for one accepted item.
    function automatic pulse_result_t predict_pulses(logic kind, logic [23:0] amt);
        pulse_result_t r;
        longint unsigned bills, coins;
        r = '0;
        r.status = ST_TICK;
        if (kind == REQ_TICK)
            advance_ms();
        else if (train_on || coin_waiting)
            r.status = ST_BUSY;
        else if (amt == 24'd0)
            r.status = ST_ZERO;
        else if (!plan_split(amt, bills, coins))
            r.status = ST_FAILED;
        else
        begin
            r.status      = ST_STARTED;
            r.bill_pulses = bills[23:0];
            r.coin_pulses = coins[23:0];
            if (r.bill_pulses != 24'd0)
            begin
                coin_waiting       = (r.coin_pulses != 24'd0);
                coin_waiting_count = coin_waiting ? r.coin_pulses : 24'd0;
                start_train(1'b0, r.bill_pulses);
            end
            else
            begin
                coin_waiting       = 1'b0;
                coin_waiting_count = 24'd0;
                start_train(1'b1, r.coin_pulses);
            end
        end
        r.bill_line = train_on && line_hi && !train_is_coin;
        r.coin_line = train_on && line_hi && train_is_coin;
        r.busy      = train_on || coin_waiting;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one item and waits for its transfer; called at a rising edge.
    task automatic send_item(logic kind, logic [23:0] amt, bit quick);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= amt;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_pulses(kind, amt));
        gap = (quick || tx_calm) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every expected result has been taken.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write while no result is outstanding.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PAY_MODE:     mode_r      = val[1:0];
            CFG_BILL_UNIT:    bill_unit_r = val;
            CFG_COIN_UNIT:    coin_unit_r = val;
            CFG_BILL_HIGH_MS: bill_high_r = val;
            CFG_BILL_LOW_MS:  bill_low_r  = val;
            CFG_COIN_HIGH_MS: coin_high_r = val;
            CFG_COIN_LOW_MS:  coin_low_r  = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_times(logic [15:0] bh, logic [15:0] bl,
                             logic [15:0] ch, logic [15:0] cl);
        write_reg(CFG_BILL_HIGH_MS, bh);
        write_reg(CFG_BILL_LOW_MS, bl);
        write_reg(CFG_COIN_HIGH_MS, ch);
        write_reg(CFG_COIN_LOW_MS, cl);
    endtask

    task automatic set_split(logic [1:0] m, logic [15:0] b, logic [15:0] c);
        write_reg(CFG_PAY_MODE, {14'd0, m});
        write_reg(CFG_BILL_UNIT, b);
        write_reg(CFG_COIN_UNIT, c);
    endtask

    // Ticks until the shadow train is over.
    task automatic drain_trains(bit quick);
        int n;
        n = 0;
        while ((train_on || coin_waiting) && n < 200000)
        begin
            send_item(REQ_TICK, 24'($urandom), quick);
            n++;
        end
    endtask

    function automatic logic [23:0] pick_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 24'd0;
        if (r < 8)
            return 24'($urandom);
        if (r < 60)
            return 24'(bill_unit_r * $urandom_range(0, 4)
                       + coin_unit_r * $urandom_range(0, 4));
        return 24'($urandom_range(1, 400));
    endfunction

    // Extremes of the fields, every status and the split corner cases.
    task automatic test_directed();
        set_times(16'd0, 16'd1, 16'd2, 16'd0);
        send_item(REQ_PAY, 24'd0, 0);
        send_item(REQ_PAY, 24'd130, 0);
        send_item(REQ_PAY, 24'd50, 0);
        send_item(REQ_TICK, 24'hFFFFFF, 0);
        drain_trains(0);
        // No exact split: the search gives up on the coin period.
        set_split(2'd0, 16'd4, 16'd6);
        send_item(REQ_PAY, 24'd1001, 0);
        send_item(REQ_PAY, 24'd3, 0);
        // Mode value 3 behaves like bills and coins.
        write_reg(CFG_PAY_MODE, 16'd3);
        send_item(REQ_PAY, 24'd14, 0);
        drain_trains(0);
        set_split(2'd0, 16'd0, 16'd7);
        send_item(REQ_PAY, 24'd15, 0);
        send_item(REQ_PAY, 24'd21, 0);
        drain_trains(0);
        set_split(2'd0, 16'd5, 16'd0);
        send_item(REQ_PAY, 24'd15, 0);
        drain_trains(0);
        set_split(2'd0, 16'd0, 16'd0);
        send_item(REQ_PAY, 24'd15, 0);
        set_split(MODE_COINS_ONLY, 16'd0, 16'hFFFF);
        send_item(REQ_PAY, 24'd100, 0);
        send_item(REQ_PAY, 24'd131070, 0);
        drain_trains(1);
        // The widest amount is not a whole number of the widest bill.
        set_split(2'd0, 16'hFFFF, 16'd0);
        send_item(REQ_PAY, 24'hFFFFFF, 0);
        set_split(MODE_BILLS_ONLY, 16'hFFFF, 16'd0);
        send_item(REQ_PAY, 24'd131069, 0);
        drain_trains(1);
        set_split(2'd0, 16'hFFFF, 16'hFFFF);
        send_item(REQ_PAY, 24'd65534, 0);
        send_item(REQ_PAY, 24'd65535, 0);
        drain_trains(0);
    endtask

    // Register changes during a train and long level times.
    task automatic test_time_regs();
        set_split(MODE_BILLS_ONLY, 16'd1, 16'd1);
        set_times(16'd3, 16'd2, 16'd1, 16'd1);
        send_item(REQ_PAY, 24'd3, 0);
        repeat (4) send_item(REQ_TICK, 24'd0, 0);
        set_times(16'd1, 16'd4, 16'd0, 16'd0);
        drain_trains(0);
        set_times(16'd20, 16'd0, 16'd0, 16'd20);
        send_item(REQ_PAY, 24'd1, 0);
        drain_trains(1);
        set_split(MODE_COINS_ONLY, 16'd1, 16'd1);
        send_item(REQ_PAY, 24'd1, 0);
        drain_trains(1);
    endtask

    // Random items under changing settings.
    task automatic test_random(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                r = $urandom_range(0, 9);
                set_split(2'($urandom), (r == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                          (r == 1) ? 16'($urandom) : 16'($urandom_range(0, 30)));
                set_times(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                          16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 75 && (train_on || coin_waiting))
                send_item(REQ_TICK, 24'($urandom), 0);
            else
                send_item(REQ_PAY, pick_amount(), 0);
        end
        tx_calm = 0;
        rx_calm = 0;
    endtask

    // The receiver holds off while items keep coming, then the sender waits out.
    task automatic test_backpressure();
        set_split(2'd0, 16'd10, 16'd3);
        set_times(16'd1, 16'd1, 16'd1, 16'd1);
        hold_start = 1;
        send_item(REQ_PAY, 24'd26, 1);
        for (int i = 0; i < 20; i++)
            send_item(REQ_TICK, 24'd0, 1);
        wait_idle();
        drain_trains(0);
    endtask

    // Receiver readiness: random stalls, calm stretches and one long hold-off.
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 99) < 25)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                        : $urandom_range(1, 3);
        end
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        pulse_result_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.bill_line   = m_tdata[0];
            got.coin_line   = m_tdata[1];
            got.busy        = m_tdata[2];
            got.bill_pulses = m_tdata[26:3];
            got.coin_pulses = m_tdata[50:27];
            got.status      = m_tuser;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.bill_line !== want.bill_line)
                begin
                    $display("%0t: bill_line expected %0d got %0d", $time,
                             want.bill_line, got.bill_line);
                    errors++;
                end
                if (got.coin_line !== want.coin_line)
                begin
                    $display("%0t: coin_line expected %0d got %0d", $time,
                             want.coin_line, got.coin_line);
                    errors++;
                end
                if (got.busy !== want.busy)
                begin
                    $display("%0t: busy expected %0d got %0d", $time, want.busy, got.busy);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, got.status);
                    errors++;
                end
                if (got.bill_pulses !== want.bill_pulses)
                begin
                    $display("%0t: bill_pulses expected %0d got %0d", $time,
                             want.bill_pulses, got.bill_pulses);
                    errors++;
                end
                if (got.coin_pulses !== want.coin_pulses)
                begin
                    $display("%0t: coin_pulses expected %0d got %0d", $time,
                             want.coin_pulses, got.coin_pulses);
                    errors++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        errors     = 0;
        cycles     = 0;
        tx_calm    = 0;
        rx_calm    = 0;
        hold_start = 0;
        hold_left  = 0;
        stall_left = 0;
        mode_r      = 2'd0;
        bill_unit_r = 16'd100;
        coin_unit_r = 16'd10;
        bill_high_r = 16'd50;
        bill_low_r  = 16'd50;
        coin_high_r = 16'd50;
        coin_low_r  = 16'd50;
        train_on = 0; line_hi = 0; train_is_coin = 0;
        edges_left = '0; level_left = '0;
        coin_waiting = 0; coin_waiting_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A first request under the reset settings.
        send_item(REQ_PAY, 24'd1230, 0);
        send_item(REQ_TICK, 24'd0, 0);
        wait_idle();
        test_directed();
        test_time_regs();
        test_backpressure();
        test_random(300);
        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
